>>> src/sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared widths, register codes, reset values and types of the stereo
// feedback delay.
// ----------------------------------------------------------------------------
package sfd_pkg;

   // Store depth; must be a power of two so that pointers wrap on their own.
   localparam int BUFFER_DEPTH = 131072;
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH);

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int DELAY_W  = 17;
   localparam int CHAN_W   = 2;
   localparam int FRAC_W   = 15;

   // Product of an unsigned gain and a signed sample, and the sum of two.
   localparam int PROD_W = GAIN_W + 1 + SAMPLE_W;
   localparam int ACC_W  = PROD_W + 1;
   localparam int QUO_W  = ACC_W - FRAC_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 17;
   localparam logic [CSR_ADDR_W-1:0] CSR_DELAY    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DRY      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WET      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FEEDBACK = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHANNELS = 3'd4;

   localparam logic [DELAY_W-1:0] DELAY_RESET    = 17'd24000;
   localparam logic [GAIN_W-1:0]  DRY_RESET      = 16'd32768;
   localparam logic [GAIN_W-1:0]  WET_RESET      = 16'd0;
   localparam logic [GAIN_W-1:0]  FEEDBACK_RESET = 16'd24576;
   localparam logic [CHAN_W-1:0]  CHANNELS_RESET = 2'd2;
   localparam logic [CHAN_W-1:0]  CHANNELS_MONO  = 2'd1;

   // Output queue that decouples the pipeline from result back-pressure.
   localparam int FIFO_DEPTH = 4;
   localparam int FPTR_W     = $clog2(FIFO_DEPTH);
   localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic [GAIN_W-1:0] dry;
      logic [GAIN_W-1:0] wet;
      logic [GAIN_W-1:0] feedback;
   } gain_set_type;

   typedef struct packed {
      logic              issue;
      logic [ADDR_W-1:0] rd_addr;
      logic [ADDR_W-1:0] wr_addr;
      logic              clear;
      logic [ADDR_W-1:0] clear_addr;
   } lane_ctl_type;

   // Divide by 2^15 rounding half up, then saturate to the sample range.
   function automatic sample_type round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] r;
      logic        [QUO_W-1:0] q;
      logic        [QUO_W-SAMPLE_W:0] top;
      sample_type  res;
      r   = acc + ACC_W'(1 << (FRAC_W - 1));
      q   = r[ACC_W-1:FRAC_W];
      top = q[QUO_W-1:SAMPLE_W-1];
      if (top == '0 || top == '1) begin
         res = q[SAMPLE_W-1:0];
      end else if (q[QUO_W-1]) begin
         res = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage
`default_nettype wire

>>> src/sfd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_ram
// Simple dual-port RAM, one write and one registered read port.
// A read at the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module sfd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> src/sfd_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_lane
// One channel of the echo: its store, the delayed-sample bypass, the
// feedback write-back and the dry/wet mix.
// ----------------------------------------------------------------------------
module sfd_lane (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sfd_pkg::lane_ctl_type ctl,
   input  wire sfd_pkg::gain_set_type gains,
   input  wire sfd_pkg::sample_type   sample_in,
   output sfd_pkg::sample_type        sample_out
);
   import sfd_pkg::*;

   // stage 1: delayed sample arrives from the store
   logic              s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0] s1_rd_addr_ff;
   logic [ADDR_W-1:0] s1_wr_addr_ff;
   sample_type        s1_sample_ff;

   // stage 2: store value written back, mix products
   logic              s2_valid_ff, s2_valid_in;
   logic [ADDR_W-1:0] s2_addr_ff;
   sample_type        s2_data_ff, s2_data_in;
   logic signed [PROD_W-1:0] s2_dry_ff, s2_dry_in;
   logic signed [PROD_W-1:0] s2_wet_ff, s2_wet_in;

   // stage 3: the write that landed while a read was issued
   logic              s3_valid_ff, s3_valid_in;
   logic [ADDR_W-1:0] s3_addr_ff;
   sample_type        s3_data_ff;

   logic [SAMPLE_W-1:0] ram_rd_data;
   logic [SAMPLE_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic                ram_wr_en;

   sample_type               delayed;
   logic signed [GAIN_W:0]   fb_s, dry_s, wet_s;
   logic signed [PROD_W-1:0] fb_prod;
   logic signed [ACC_W-1:0]  store_acc, mix_acc;

   sfd_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ctl.issue),
      .rd_addr (ctl.rd_addr),
      .rd_data (ram_rd_data)
   );

   // Clear sweep owns the write port until it ends.
   always_comb begin
      if (ctl.clear) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = ctl.clear_addr;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s2_valid_ff;
         ram_wr_addr = s2_addr_ff;
         ram_wr_data = s2_data_ff;
      end
   end

   // Bypass writes not yet visible to the read; the youngest wins.
   always_comb begin
      if (s2_valid_ff && s2_addr_ff == s1_rd_addr_ff) begin
         delayed = s2_data_ff;
      end else if (s3_valid_ff && s3_addr_ff == s1_rd_addr_ff) begin
         delayed = s3_data_ff;
      end else begin
         delayed = ram_rd_data;
      end
   end

   assign fb_s    = {1'b0, gains.feedback};
   assign dry_s   = {1'b0, gains.dry};
   assign wet_s   = {1'b0, gains.wet};
   assign fb_prod = fb_s * delayed;

   assign store_acc = {{(ACC_W-SAMPLE_W-FRAC_W){s1_sample_ff[SAMPLE_W-1]}},
                       s1_sample_ff, {FRAC_W{1'b0}}}
                    + {fb_prod[PROD_W-1], fb_prod};

   assign s1_valid_in = ctl.issue;
   assign s2_valid_in = s1_valid_ff;
   assign s3_valid_in = s2_valid_ff;
   assign s2_data_in  = round_sat(store_acc);
   assign s2_dry_in   = dry_s * s1_sample_ff;
   assign s2_wet_in   = wet_s * delayed;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         s1_rd_addr_ff <= ctl.rd_addr;
         s1_wr_addr_ff <= ctl.wr_addr;
         s1_sample_ff  <= sample_in;
      end
      s2_addr_ff <= s1_wr_addr_ff;
      s2_data_ff <= s2_data_in;
      s2_dry_ff  <= s2_dry_in;
      s2_wet_ff  <= s2_wet_in;
      s3_addr_ff <= s2_addr_ff;
      s3_data_ff <= s2_data_ff;
   end

   assign mix_acc    = {s2_dry_ff[PROD_W-1], s2_dry_ff} + {s2_wet_ff[PROD_W-1], s2_wet_ff};
   assign sample_out = round_sat(mix_acc);

endmodule
`default_nettype wire

>>> src/sfd_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_merge
// Join the lane results into one frame and queue it for the result channel.
// ----------------------------------------------------------------------------
module sfd_merge (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic                  mono,
   input  wire sfd_pkg::sample_type   left_val,
   input  wire sfd_pkg::sample_type   right_val,
   output logic [sfd_pkg::LVL_W-1:0]  level,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [2*sfd_pkg::SAMPLE_W-1:0] rsp_tdata   // [15:0] left_out, [31:16] right_out
);
   import sfd_pkg::*;

   logic [2*SAMPLE_W-1:0] entry_ff [FIFO_DEPTH];
   logic [2*SAMPLE_W-1:0] entry_in;
   logic [FPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]      level_ff, level_in;
   logic                  pop;
   sample_type            right_sel;

   // Drop the right lane in mono mode.
   assign right_sel = mono ? '0 : right_val;
   assign entry_in  = {right_sel, left_val};

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (level_ff != '0);
   assign rsp_tdata  = entry_ff[rd_ptr_ff];
   assign level      = level_ff;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      case ({push, pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> level_ff < LVL_W'(FIFO_DEPTH))
   else $error("result queue written while full");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_W'(FIFO_DEPTH))
   else $error("result queue level out of range");

   // A stalled result item holds still until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   else $error("result item changed while stalled");

endmodule
`default_nettype wire

>>> src/stereo_feedback_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_feedback_delay
// Stereo feedback echo: two channel lanes, each with its own delay store,
// merged into one result frame per input frame.
// ----------------------------------------------------------------------------
// Pipeline: an accepted frame passes the lane stage 1 and stage 2 registers,
//   is then pushed into the result queue and raises rsp_tvalid.
// Throughput: one frame per cycle while req_tready is high. Per frame, each
//   running lane (left only in mono mode) reads and writes its dual-port store once.
// Reset: synchronous, active high. Registers take their reset values, the
//   write pointer goes to zero, and a clearing pass zeroes every store entry,
//   one per cycle, with req_tready low until the sweep ends.
// ----------------------------------------------------------------------------
module stereo_feedback_delay (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input frames
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [2*sfd_pkg::SAMPLE_W-1:0]  req_tdata,  // [15:0] left_in, [31:16] right_in
   // result frames
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [2*sfd_pkg::SAMPLE_W-1:0]       rsp_tdata,  // [15:0] left_out, [31:16] right_out
   // register writes
   input  wire logic                            csr_we,
   input  wire logic [sfd_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  wire logic [sfd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sfd_pkg::*;

   // configuration registers
   logic [DELAY_W-1:0] delay_ff;
   logic [GAIN_W-1:0]  dry_ff, wet_ff, feedback_ff;
   logic [CHAN_W-1:0]  chan_ff;

   // write pointer and clear sweep
   logic [ADDR_W-1:0]  wp_ff, wp_in;
   logic               clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;

   // pipeline occupancy, used to reserve room in the result queue
   logic               p1_valid_ff, p2_valid_ff;
   logic               p1_mono_ff, p2_mono_ff;

   logic               accept;
   logic               mono;
   logic [ADDR_W-1:0]  rd_addr;
   logic [LVL_W-1:0]   level;
   logic [LVL_W:0]     committed;
   gain_set_type       gains;
   lane_ctl_type       ctl_left, ctl_right;
   sample_type         left_val, right_val;

   assign accept = req_tvalid && req_tready;
   assign mono   = (chan_ff == CHANNELS_MONO);

   // Delay is taken modulo the depth; a zero delay reads the entry about to be
   // overwritten, which is the full-depth echo.
   assign rd_addr = wp_ff - delay_ff[ADDR_W-1:0];

   // Hold off input while the store is being cleared or every queue slot is
   // spoken for by queued or in-flight frames.
   assign committed  = {1'b0, level} + (LVL_W+1)'(p1_valid_ff) + (LVL_W+1)'(p2_valid_ff);
   assign req_tready = !clr_busy_ff && (committed < (LVL_W+1)'(FIFO_DEPTH));

   assign gains.dry      = dry_ff;
   assign gains.wet      = wet_ff;
   assign gains.feedback = feedback_ff;

   // Left lane runs for every frame; the right lane sits out in mono mode.
   assign ctl_left.issue       = accept;
   assign ctl_left.rd_addr     = rd_addr;
   assign ctl_left.wr_addr     = wp_ff;
   assign ctl_left.clear       = clr_busy_ff;
   assign ctl_left.clear_addr  = clr_addr_ff;
   assign ctl_right.issue      = accept && !mono;
   assign ctl_right.rd_addr    = rd_addr;
   assign ctl_right.wr_addr    = wp_ff;
   assign ctl_right.clear      = clr_busy_ff;
   assign ctl_right.clear_addr = clr_addr_ff;

   // Advance the write pointer once per frame; it wraps with the depth.
   assign wp_in = accept ? wp_ff + 1'b1 : wp_ff;

   // Sweep every store entry once after reset.
   assign clr_addr_in = clr_addr_ff + 1'b1;
   assign clr_busy_in = clr_busy_ff && (clr_addr_ff != '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= DELAY_RESET;
         dry_ff      <= DRY_RESET;
         wet_ff      <= WET_RESET;
         feedback_ff <= FEEDBACK_RESET;
         chan_ff     <= CHANNELS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DELAY:    delay_ff    <= csr_wdata[DELAY_W-1:0];
            CSR_DRY:      dry_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_WET:      wet_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_FEEDBACK: feedback_ff <= csr_wdata[GAIN_W-1:0];
            CSR_CHANNELS: chan_ff     <= csr_wdata[CHAN_W-1:0];
            default: ;  // unknown index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         p1_valid_ff <= accept;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   // Mode rides along with the frame.
   always_ff @(posedge clock) begin
      p1_mono_ff <= mono;
      p2_mono_ff <= p1_mono_ff;
   end

   sfd_lane u_lane_left (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl_left),
      .gains      (gains),
      .sample_in  (req_tdata[SAMPLE_W-1:0]),
      .sample_out (left_val)
   );

   sfd_lane u_lane_right (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl_right),
      .gains      (gains),
      .sample_in  (req_tdata[2*SAMPLE_W-1:SAMPLE_W]),
      .sample_out (right_val)
   );

   sfd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .push       (p2_valid_ff),
      .mono       (p2_mono_ff),
      .left_val   (left_val),
      .right_val  (right_val),
      .level      (level),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // No frame enters while the store is still being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_tready)
   else $error("frame accepted during clear sweep");

   // Queued plus in-flight frames never exceed the queue depth.
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      committed <= (LVL_W+1)'(FIFO_DEPTH))
   else $error("result queue over-committed");

   // Every accepted frame advances the write pointer by exactly one.
   a_wp_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> wp_ff == $past(wp_ff) + 1'b1)
   else $error("write pointer did not advance");

   // Every accepted frame reaches the merge stage through p1_valid_ff and p2_valid_ff.
   a_push_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 p2_valid_ff)
   else $error("accepted frame lost in pipeline");

endmodule
`default_nettype wire

>>> tb/tb_stereo_feedback_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_feedback_delay
// Self-checking bench for the stereo feedback echo. Frames go in over a
// valid/ready stream with bursty gaps, and results are drained with random
// back-pressure. An in-bench echo model with its own copy of both delay
// stores predicts every result frame, and the scoreboard compares each
// received frame field by field. Register settings change only between
// phases, while nothing is in flight. The last phase uses the zero delay,
// which reads the full store depth behind the write pointer.
// ----------------------------------------------------------------------------
module tb_stereo_feedback_delay;
   import sfd_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 4_000_000;
   localparam int          RANDOM_PHASES = 8;
   localparam int          PHASE_FRAMES  = 50;
   localparam int          ZERO_DELAY_FRAMES = 64;
   localparam int          REPORT_LIMIT  = 10;
   localparam longint      SAMPLE_HI     = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint      SAMPLE_LO     = -SAMPLE_HI - 1;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1 << FRAC_W);

   // One stereo frame, laid out the way it travels in tdata.
   typedef struct packed {
      sample_type right;
      sample_type left;
   } frame_type;

   // -------------------------------------------------------------------------
   // Echo model and result scoreboard
   // -------------------------------------------------------------------------
   class echo_scoreboard;
      shortint            store_left  [BUFFER_DEPTH];
      shortint            store_right [BUFFER_DEPTH];
      int unsigned        write_ptr;
      logic [DELAY_W-1:0] delay_len;
      logic [GAIN_W-1:0]  dry_gain;
      logic [GAIN_W-1:0]  wet_gain;
      logic [GAIN_W-1:0]  feedback_gain;
      logic [CHAN_W-1:0]  channels;
      frame_type          mix_due[$];
      int                 mix_faults;

      // Both stores start cleared (2-state arrays).
      function new();
         write_ptr     = 0;
         delay_len     = DELAY_RESET;
         dry_gain      = DRY_RESET;
         wet_gain      = WET_RESET;
         feedback_gain = FEEDBACK_RESET;
         channels      = CHANNELS_RESET;
         mix_faults    = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_DELAY:    delay_len     = value[DELAY_W-1:0];
            CSR_DRY:      dry_gain      = value[GAIN_W-1:0];
            CSR_WET:      wet_gain      = value[GAIN_W-1:0];
            CSR_FEEDBACK: feedback_gain = value[GAIN_W-1:0];
            CSR_CHANNELS: channels      = value[CHAN_W-1:0];
            default: ;
         endcase
      endfunction

      // Divide by 2^15, round half up, clip to the sample range.
      function sample_type scale_round(longint acc);
         longint q;
         q = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
         if (q > SAMPLE_HI) q = SAMPLE_HI;
         if (q < SAMPLE_LO) q = SAMPLE_LO;
         return sample_type'(q);
      endfunction

      // Mix one channel against its delayed sample and write the feedback.
      function sample_type echo_lane(bit right, int unsigned rd, sample_type x);
         longint held, xin, g_dry, g_wet, g_fb;
         sample_type mixed, fed;
         held  = right ? store_right[rd] : store_left[rd];
         xin   = x;
         g_dry = dry_gain;
         g_wet = wet_gain;
         g_fb  = feedback_gain;
         mixed = scale_round(g_dry * xin + g_wet * held);
         fed   = scale_round((xin <<< FRAC_W) + g_fb * held);
         if (right) store_right[write_ptr] = fed;
         else store_left[write_ptr] = fed;
         return mixed;
      endfunction

      // Note an accepted input frame and queue the frame it must produce.
      function void take_frame(frame_type f);
         int unsigned rd;
         frame_type   e;
         rd = (write_ptr + BUFFER_DEPTH - (delay_len % BUFFER_DEPTH)) % BUFFER_DEPTH;
         e.left = echo_lane(1'b0, rd, f.left);
         // Mono leaves the right store alone and outputs silence.
         e.right = (channels == CHANNELS_MONO) ? '0 : echo_lane(1'b1, rd, f.right);
         mix_due.push_back(e);
         write_ptr = (write_ptr + 1) % BUFFER_DEPTH;
      endfunction

      function void check_result(frame_type got);
         frame_type want;
         if (mix_due.size() == 0) begin
            mix_faults++;
            if (mix_faults <= REPORT_LIMIT)
               $display("%0t: unexpected result left=%0d right=%0d", $realtime,
                        got.left, got.right);
            return;
         end
         want = mix_due.pop_front();
         if (got.left !== want.left || got.right !== want.right) begin
            mix_faults++;
            if (mix_faults <= REPORT_LIMIT)
               $display("%0t: mismatch left exp %0d got %0d, right exp %0d got %0d",
                        $realtime, want.left, got.left, want.right, got.right);
         end
      endfunction

      function int pending();
         return mix_due.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, DUT and its inputs
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [2*SAMPLE_W-1:0] req_tdata;   // [15:0] left_in, [31:16] right_in
   logic rsp_tvalid;
   logic rsp_tready;
   logic [2*SAMPLE_W-1:0] rsp_tdata;   // [15:0] left_out, [31:16] right_out
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   always #6 clock = ~clock;

   stereo_feedback_delay i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   echo_scoreboard sb = new();

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
   end

   // -------------------------------------------------------------------------
   // Monitors: note every accepted input item, check every accepted result.
   // Values read at the edge are the ones the DUT sampled.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.take_frame(frame_type'(req_tdata));
         if (rsp_tvalid && rsp_tready) sb.check_result(frame_type'(rsp_tdata));
      end
   end

   // Receiver: alternate ready and stall runs of random length; now and then
   // hold ready for a long stretch so the pipeline runs at full rate.
   int  rx_hold = 0;
   bit  rx_open = 1'b0;
   always @(posedge clock) begin
      if (rx_hold == 0) begin
         rx_open = ($urandom_range(0, 3) != 0);
         if (rx_open)
            rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
         else
            rx_hold = $urandom_range(1, 6);
      end
      rx_hold--;
      rsp_tready <= rx_open;
   end

   // Watchdog: declare a fail and stop if the run goes on too long.
   int unsigned cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stereo_feedback_delay regression: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   function automatic frame_type stereo(sample_type l, sample_type r);
      frame_type f;
      f.left  = l;
      f.right = r;
      return f;
   endfunction

   // Mostly random, with the extremes mixed in.
   function automatic sample_type rand_sample();
      case ($urandom_range(0, 9))
         0:       return sample_type'(SAMPLE_HI);
         1:       return sample_type'(SAMPLE_LO);
         2:       return '0;
         3:       return '1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] rand_gain();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return GAIN_UNITY;
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   // Send frames in bursts of random length with random gaps between them.
   task automatic push_frames(input frame_type frames[$]);
      int burst_left;
      int gap;
      burst_left = 0;
      foreach (frames[k]) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_tvalid <= 1'b1;
         req_tdata  <= frames[k];
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         burst_left--;
      end
      req_tvalid <= 1'b0;
   endtask

   // Hold until every expected result has come back.
   task automatic drain();
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Leave csr_we high across back-to-back writes; the caller drops it.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(index, value);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] delay_len,
                                 input logic [CSR_DATA_W-1:0] dry,
                                 input logic [CSR_DATA_W-1:0] wet,
                                 input logic [CSR_DATA_W-1:0] feedback,
                                 input logic [CSR_DATA_W-1:0] channels,
                                 input bit stray);
      // Writes to unused indexes must leave every register alone.
      if (stray)
         for (int k = int'(CSR_CHANNELS) + 1; k < (1 << CSR_ADDR_W); k++)
            write_reg(CSR_ADDR_W'(k), CSR_DATA_W'($urandom));
      write_reg(CSR_DELAY, delay_len);
      write_reg(CSR_DRY, dry);
      write_reg(CSR_WET, wet);
      write_reg(CSR_FEEDBACK, feedback);
      write_reg(CSR_CHANNELS, channels);
      csr_we <= 1'b0;
   endtask

   // Random settings, biased toward short delays so echoes come back within
   // a phase. Unused high bits of the write data are randomized too.
   task automatic random_settings();
      logic [CSR_DATA_W-1:0] delay_len;
      case ($urandom_range(0, 9))
         0:       delay_len = '0;
         1:       delay_len = CSR_DATA_W'(BUFFER_DEPTH - 1);
         2:       delay_len = CSR_DATA_W'($urandom);
         3:       delay_len = CSR_DATA_W'($urandom_range(41, 600));
         default: delay_len = CSR_DATA_W'($urandom_range(1, 40));
      endcase
      apply_settings(delay_len,
                     {1'($urandom), rand_gain()},
                     {1'($urandom), rand_gain()},
                     {1'($urandom), rand_gain()},
                     {15'($urandom), CHAN_W'($urandom)},
                     $urandom_range(0, 3) == 0);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      frame_type frames[$];

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // Wait out the store clearing pass.
      do @(posedge clock); while (!req_tready);

      // Short delay, unity mix, feedback near 2.0: echoes pile up and clip.
      apply_settings(3, GAIN_UNITY, GAIN_UNITY, 16'hFFFF, 2, 1'b0);
      frames = {stereo(16'sh7FFF, 16'sh8000), stereo(16'sh8000, 16'sh7FFF),
                stereo(0, 0), stereo(-1, 1), stereo(16'sh7FFF, 16'sh7FFF),
                stereo(16'sh8000, 16'sh8000), stereo(1, -1), stereo(0, 0),
                stereo(16384, -16384), stereo(-1, -1)};
      push_frames(frames);
      drain();

      // Mono, one-sample delay, both mix gains at maximum, no feedback.
      apply_settings(1, 16'hFFFF, 16'hFFFF, 0, CHANNELS_MONO, 1'b0);
      frames = {stereo(16'sh7FFF, 16'sh1234), stereo(16'sh8000, -1),
                stereo(-1, 16'sh7FFF), stereo(1, 16'sh8000),
                stereo(0, 16'sh5555), stereo(-16384, 16'sh2AAA)};
      push_frames(frames);
      drain();

      // Channel code 0 counts as stereo; longest delay; mix gains zero.
      apply_settings(CSR_DATA_W'(BUFFER_DEPTH - 1), 0, 0, GAIN_UNITY, 0, 1'b0);
      frames = {stereo(16'sh7FFF, 16'sh8000), stereo(rand_sample(), rand_sample()),
                stereo(16'sh8000, 16'sh7FFF), stereo(-1, 1)};
      push_frames(frames);
      drain();

      // Channel code 3 is stereo too; oversized write data gets truncated,
      // and writes to unused indexes change nothing.
      apply_settings(2, 17'h1FFFF, {1'b1, GAIN_UNITY}, 17'h10000, 17'h1FFFF, 1'b1);
      frames = {stereo(16'sh7FFF, 16'sh7FFF), stereo(16'sh8000, 16'sh8000),
                stereo(12345, -12345), stereo(16'sh7FFF, 16'sh8000), stereo(0, 0)};
      push_frames(frames);
      drain();

      // Random phases.
      repeat (RANDOM_PHASES) begin
         random_settings();
         frames = {};
         repeat (PHASE_FRAMES) frames.push_back(stereo(rand_sample(), rand_sample()));
         push_frames(frames);
         drain();
      end

      // Zero delay means full depth: every read lands on the entry about to be
      // overwritten, which still holds its cleared value this early.
      apply_settings(0, {1'b0, rand_gain()}, GAIN_W'($urandom_range(1, 65535)),
                     {1'b0, rand_gain()}, 2, 1'b0);
      frames = {};
      repeat (ZERO_DELAY_FRAMES) frames.push_back(stereo(rand_sample(), rand_sample()));
      push_frames(frames);
      drain();

      // Let the pipeline settle so any stray result shows up.
      repeat (8) @(posedge clock);
      if (sb.mix_faults == 0 && sb.pending() == 0) begin
         $display("stereo_feedback_delay regression: pass");
      end else begin
         $display("stereo_feedback_delay regression: fail");
      end
      $finish;
   end

endmodule
